// File: rtl/mmac_pkg.sv
// ----------------------------------------------------------------------------
// mmac_pkg
// Shared types and constants of the matrix multiply-accumulate block.
// ----------------------------------------------------------------------------
package mmac_pkg;

  // Default sizes handed to the top level
  localparam int N_MAX_DEF = 16;
  localparam int TILE_DEF  = 4;

  // Fixed field widths
  localparam int CMD_W  = 3;
  localparam int IDX_W  = 4;
  localparam int AB_W   = 16;
  localparam int C_W    = 48;
  localparam int PROD_W = 2 * AB_W;
  localparam int SIZE_W = 5;

  localparam logic [SIZE_W-1:0] SIZE_RST = 5'd16;

  localparam logic signed [C_W-1:0] C_MAX = {1'b0, {(C_W-1){1'b1}}};
  localparam logic signed [C_W-1:0] C_MIN = {1'b1, {(C_W-1){1'b0}}};

  // Item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_WR_A    = 3'd0,
    CMD_WR_B    = 3'd1,
    CMD_WR_C    = 3'd2,
    CMD_COMPUTE = 3'd3,
    CMD_RD_C    = 3'd4
  } cmd_t;

  // Compute sequencer states
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MAC   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  // Status from the multiply-accumulate datapath
  typedef struct packed {
    logic pipe_busy;
    logic clip;
  } mac_stat_t;

endpackage

// File: rtl/mmac_mac.sv
// ----------------------------------------------------------------------------
// mmac_mac
// Product and accumulate stages, plus the saturating add onto the C entry.
// ----------------------------------------------------------------------------
module mmac_mac #(
  parameter int N_MAX = mmac_pkg::N_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [mmac_pkg::AB_W-1:0]    a_data,
  input  logic signed [mmac_pkg::AB_W-1:0]    b_data,
  input  logic                                data_vld,
  input  logic                                acc_clr,
  input  logic signed [mmac_pkg::C_W-1:0]     c_data,
  output logic signed [mmac_pkg::C_W-1:0]     c_new,
  output mmac_pkg::mac_stat_t                 stat
);

  localparam int ACC_W = mmac_pkg::PROD_W + $clog2(N_MAX);
  localparam int SUM_W = mmac_pkg::C_W + 1;

  logic signed [mmac_pkg::PROD_W-1:0] prod_r;
  logic                               prod_vld_r;
  logic signed [ACC_W-1:0]            acc_r;
  logic signed [SUM_W-1:0]            sum;
  logic                               clip;

  // Register the product, then fold it into the running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= data_vld;
    end
    prod_r <= a_data * b_data;
    if (acc_clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Add the exact sum to the old entry and clip to the 48-bit range
  always_comb begin
    sum  = SUM_W'(c_data) + SUM_W'(acc_r);
    clip = sum[SUM_W-1] ^ sum[SUM_W-2];
    if (clip) begin
      c_new = sum[SUM_W-1] ? mmac_pkg::C_MIN : mmac_pkg::C_MAX;
    end else begin
      c_new = sum[mmac_pkg::C_W-1:0];
    end
  end

  assign stat.pipe_busy = data_vld | prod_vld_r;
  assign stat.clip      = clip;

endmodule

// File: rtl/matrix_multiply_accumulate.sv
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate
// C += A*B over n x n matrices held in three on-chip stores.
// ----------------------------------------------------------------------------
// Channel  Ports                                   Handshake
// input    in_command, in_row_index, in_col_index, start, busy (taken when
//          in_value                                start high, busy low)
// result   out_value, out_compute_done,            out_valid, one cycle,
//          out_saturated                           no back-pressure
// config   cfg_wdata                               cfg_we
//
// An element write is stored at the accepting edge; a read of C returns its
// item in the cycle after the accept, and the next item may follow at once.
// A compute holds busy: per C entry, A/B reads issue through one multiplier
// lane, then the memory, product and accumulate stages drain and write C back.
// The done item is on the outputs in the first cycle with busy low again (the
// cycle after the accept for size zero). Reset is synchronous; the stores are
// not cleared. The receiver cannot stall the result side.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate #(
  parameter int N_MAX = mmac_pkg::N_MAX_DEF,
  parameter int TILE  = mmac_pkg::TILE_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [mmac_pkg::CMD_W-1:0]         in_command,
  input  logic [mmac_pkg::IDX_W-1:0]         in_row_index,
  input  logic [mmac_pkg::IDX_W-1:0]         in_col_index,
  input  logic signed [mmac_pkg::C_W-1:0]    in_value,
  output logic                               out_valid,
  output logic signed [mmac_pkg::C_W-1:0]    out_value,
  output logic                               out_compute_done,
  output logic                               out_saturated,
  input  logic                               cfg_we,
  input  logic [mmac_pkg::SIZE_W-1:0]        cfg_wdata
);

  localparam int CELLS = N_MAX * N_MAX;
  localparam int AW    = $clog2(CELLS);
  localparam int IW    = $clog2(N_MAX);
  localparam int NW    = $clog2(N_MAX + 1);
  localparam int SW    = $clog2(N_MAX + TILE + 1);

  // Stores
  logic signed [mmac_pkg::AB_W-1:0] a_mem [CELLS];
  logic signed [mmac_pkg::AB_W-1:0] b_mem [CELLS];
  logic signed [mmac_pkg::C_W-1:0]  c_mem [CELLS];

  mmac_pkg::state_t state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, ib_r, ib_nxt, jb_r, jb_nxt;
  logic [NW-1:0] n_r, n_nxt, n_eff;
  logic          ovf_r, ovf_nxt, done_r, done_nxt;
  logic          rd_pend_r, rd_in_r, rd_vld_r;
  logic [mmac_pkg::SIZE_W-1:0] cfg_size_r;

  logic signed [mmac_pkg::AB_W-1:0] a_q_r, b_q_r;
  logic signed [mmac_pkg::C_W-1:0]  c_q_r, c_new;
  mmac_pkg::mac_stat_t              stat;
  mmac_pkg::cmd_t                   cmd;

  logic          accept, in_range, acc_clr, c_we, k_last, c_rd_en;
  logic [AW-1:0] host_addr, a_addr, b_addr, c_addr, c_rd_addr;
  logic [SW-1:0] nn, i1, j1, iend, jend;

  // Decode the item
  assign cmd       = mmac_pkg::cmd_t'(in_command);
  assign busy      = (state_r != mmac_pkg::S_IDLE);
  assign accept    = start & ~busy;
  assign in_range  = (int'(in_row_index) < N_MAX) && (int'(in_col_index) < N_MAX);
  assign host_addr = AW'(in_row_index) * AW'(N_MAX) + AW'(in_col_index);

  // Compute addresses
  assign a_addr    = AW'(i_r) * AW'(N_MAX) + AW'(k_r);
  assign b_addr    = AW'(k_r) * AW'(N_MAX) + AW'(j_r);
  assign c_addr    = AW'(i_r) * AW'(N_MAX) + AW'(j_r);
  assign c_rd_addr = busy ? c_addr : host_addr;

  assign n_eff = (int'(cfg_size_r) > N_MAX) ? NW'(N_MAX) : NW'(cfg_size_r);
  assign nn    = SW'(n_r);
  assign i1    = SW'(i_r) + SW'(1);
  assign j1    = SW'(j_r) + SW'(1);
  assign iend  = SW'(ib_r) + SW'(TILE);
  assign jend  = SW'(jb_r) + SW'(TILE);
  assign k_last = (SW'(k_r) + SW'(1)) == nn;
  assign c_rd_en = ((state_r == mmac_pkg::S_MAC) && k_last) ||
                   (accept && (cmd == mmac_pkg::CMD_RD_C));

  // Sequence the compute: tile blocks of C, full k sweep per entry
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    ib_nxt    = ib_r;
    jb_nxt    = jb_r;
    n_nxt     = n_r;
    ovf_nxt   = ovf_r;
    done_nxt  = 1'b0;
    acc_clr   = 1'b0;
    c_we      = 1'b0;
    case (state_r)
      mmac_pkg::S_IDLE: begin
        if (accept && (cmd == mmac_pkg::CMD_COMPUTE)) begin
          ovf_nxt = 1'b0;
          acc_clr = 1'b1;
          n_nxt   = n_eff;
          i_nxt   = '0;
          j_nxt   = '0;
          k_nxt   = '0;
          ib_nxt  = '0;
          jb_nxt  = '0;
          if (n_eff == '0) begin
            done_nxt = 1'b1;
          end else begin
            state_nxt = mmac_pkg::S_MAC;
          end
        end
      end
      mmac_pkg::S_MAC: begin
        k_nxt = k_r + IW'(1);
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = mmac_pkg::S_DRAIN;
        end
      end
      mmac_pkg::S_DRAIN: begin
        if (!stat.pipe_busy) begin
          c_we      = 1'b1;
          acc_clr   = 1'b1;
          state_nxt = mmac_pkg::S_MAC;
          if (stat.clip) begin
            ovf_nxt = 1'b1;
          end
          if ((j1 < jend) && (j1 < nn)) begin
            j_nxt = IW'(j1);
          end else if ((i1 < iend) && (i1 < nn)) begin
            i_nxt = IW'(i1);
            j_nxt = jb_r;
          end else if (jend < nn) begin
            jb_nxt = IW'(jend);
            j_nxt  = IW'(jend);
            i_nxt  = ib_r;
          end else if (iend < nn) begin
            ib_nxt = IW'(iend);
            i_nxt  = IW'(iend);
            jb_nxt = '0;
            j_nxt  = '0;
          end else begin
            state_nxt = mmac_pkg::S_IDLE;
            done_nxt  = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = mmac_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mmac_pkg::S_IDLE;
      ovf_r      <= 1'b0;
      done_r     <= 1'b0;
      rd_pend_r  <= 1'b0;
      rd_vld_r   <= 1'b0;
      cfg_size_r <= mmac_pkg::SIZE_RST;
    end else begin
      state_r   <= state_nxt;
      ovf_r     <= ovf_nxt;
      done_r    <= done_nxt;
      rd_pend_r <= accept && (cmd == mmac_pkg::CMD_RD_C);
      rd_vld_r  <= (state_r == mmac_pkg::S_MAC);
      if (cfg_we) begin
        cfg_size_r <= cfg_wdata;
      end
    end
  end

  // Counters and read-side flags
  always_ff @(posedge clk) begin
    i_r  <= i_nxt;
    j_r  <= j_nxt;
    k_r  <= k_nxt;
    ib_r <= ib_nxt;
    jb_r <= jb_nxt;
    n_r  <= n_nxt;
    if (accept) begin
      rd_in_r <= in_range;
    end
  end

  // A and B stores: host writes, compute reads
  always_ff @(posedge clk) begin
    if (accept && (cmd == mmac_pkg::CMD_WR_A) && in_range) begin
      a_mem[host_addr] <= in_value[mmac_pkg::AB_W-1:0];
    end
    if (accept && (cmd == mmac_pkg::CMD_WR_B) && in_range) begin
      b_mem[host_addr] <= in_value[mmac_pkg::AB_W-1:0];
    end
    a_q_r <= a_mem[a_addr];
    b_q_r <= b_mem[b_addr];
  end

  // C store: host write or compute write-back; one shared read port
  always_ff @(posedge clk) begin
    if (c_we) begin
      c_mem[c_addr] <= c_new;
    end else if (accept && (cmd == mmac_pkg::CMD_WR_C) && in_range) begin
      c_mem[host_addr] <= in_value;
    end
    if (c_rd_en) begin
      c_q_r <= c_mem[c_rd_addr];
    end
  end

  mmac_mac #(
    .N_MAX (N_MAX)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .a_data   (a_q_r),
    .b_data   (b_q_r),
    .data_vld (rd_vld_r),
    .acc_clr  (acc_clr),
    .c_data   (c_q_r),
    .c_new    (c_new),
    .stat     (stat)
  );

  // Present the result item
  assign out_valid        = rd_pend_r | done_r;
  assign out_value        = (rd_pend_r && rd_in_r) ? c_q_r : '0;
  assign out_compute_done = done_r;
  assign out_saturated    = ovf_r;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for matrix_multiply_accumulate. Loads every entry of
// the A, B and C stores, runs directed corner items (saturation both ways,
// size zero, size above the store, unused commands) and then random phases
// at several matrix sizes. A mirror of the stores predicts every read and
// done item, and each prediction is compared field by field with its result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int N_MAX  = mmac_pkg::N_MAX_DEF;
  localparam int CELLS  = N_MAX * N_MAX;
  localparam int CMD_W  = mmac_pkg::CMD_W;
  localparam int IDX_W  = mmac_pkg::IDX_W;
  localparam int AB_W   = mmac_pkg::AB_W;
  localparam int C_W    = mmac_pkg::C_W;
  localparam int SIZE_W = mmac_pkg::SIZE_W;

  // Commands the block ignores
  localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef struct {
    logic signed [C_W-1:0] value;
    logic                  done;
    logic                  sat;
  } mmac_result_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [CMD_W-1:0]         in_command = '0;
  logic [IDX_W-1:0]         in_row_index = '0;
  logic [IDX_W-1:0]         in_col_index = '0;
  logic signed [C_W-1:0]    in_value = '0;
  logic                     out_valid;
  logic signed [C_W-1:0]    out_value;
  logic                     out_compute_done;
  logic                     out_saturated;
  logic                     cfg_we = 1'b0;
  logic [SIZE_W-1:0]        cfg_wdata = '0;

  // Mirror of the block's stores and flags
  logic signed [AB_W-1:0]   a_mirror [CELLS];
  logic signed [AB_W-1:0]   b_mirror [CELLS];
  logic signed [C_W-1:0]    c_mirror [CELLS];
  logic                     sat_mirror = 1'b0;
  logic [SIZE_W-1:0]        size_mirror = mmac_pkg::SIZE_RST;

  mmac_result_t             pending_results [$];
  int                       error_count = 0;
  int                       idle_pct = 19;

  matrix_multiply_accumulate dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_value        (out_value),
    .out_compute_done (out_compute_done),
    .out_saturated    (out_saturated),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bound the run
  initial begin
    #4000000;
    $display("matrix_multiply_accumulate verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("%0t ns: mismatch: %s", $realtime, msg);
  endtask

  // Accumulate A*B into C over the active size, clipping each entry
  function automatic void mirror_compute();
    int     n;
    longint acc;
    longint total;
    n = (size_mirror > N_MAX) ? N_MAX : int'(size_mirror);
    sat_mirror = 1'b0;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int k = 0; k < n; k++)
          acc += longint'(a_mirror[i*N_MAX+k]) * longint'(b_mirror[k*N_MAX+j]);
        total = longint'(c_mirror[i*N_MAX+j]) + acc;
        if (total > longint'(mmac_pkg::C_MAX)) begin
          total = longint'(mmac_pkg::C_MAX);
          sat_mirror = 1'b1;
        end else if (total < longint'(mmac_pkg::C_MIN)) begin
          total = longint'(mmac_pkg::C_MIN);
          sat_mirror = 1'b1;
        end
        c_mirror[i*N_MAX+j] = C_W'(total);
      end
    end
  endfunction

  // Apply one accepted item to the mirror and queue what it should answer
  function automatic void mirror_item(input logic [CMD_W-1:0] cmd,
                                      input logic [IDX_W-1:0] row,
                                      input logic [IDX_W-1:0] col,
                                      input logic signed [C_W-1:0] val);
    int           idx;
    mmac_result_t res;
    idx = int'(row) * N_MAX + int'(col);
    case (cmd)
      mmac_pkg::CMD_WR_A: a_mirror[idx] = val[AB_W-1:0];
      mmac_pkg::CMD_WR_B: b_mirror[idx] = val[AB_W-1:0];
      mmac_pkg::CMD_WR_C: c_mirror[idx] = val;
      mmac_pkg::CMD_COMPUTE: begin
        mirror_compute();
        res.value = '0;
        res.done  = 1'b1;
        res.sat   = sat_mirror;
        pending_results.push_back(res);
      end
      mmac_pkg::CMD_RD_C: begin
        res.value = c_mirror[idx];
        res.done  = 1'b0;
        res.sat   = sat_mirror;
        pending_results.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // Offer one item, idling first at random, and hold it until taken
  task automatic send_item(input logic [CMD_W-1:0] cmd,
                           input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col,
                           input logic signed [C_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_command   <= cmd;
    in_row_index <= row;
    in_col_index <= col;
    in_value     <= val;
    do @(posedge clk); while (busy !== 1'b0);
    mirror_item(cmd, row, col, val);
  endtask

  // Drop start and let every result and any trailing write drain
  task automatic wait_quiet();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_size(input logic [SIZE_W-1:0] n);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we      <= 1'b0;
    size_mirror = n;
  endtask

  function automatic logic signed [C_W-1:0] rand_ab_value();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(7))
      0: raw[AB_W-1:0] = 16'h8000;
      1: raw[AB_W-1:0] = 16'h7FFF;
      default: ;
    endcase
    return raw[C_W-1:0];
  endfunction

  // Bias C towards the clipping limits so that computes saturate now and then
  function automatic logic signed [C_W-1:0] rand_c_value();
    logic [63:0]          raw;
    logic signed [C_W-1:0] gap;
    raw = {$urandom, $urandom};
    gap = C_W'($urandom >> $urandom_range(31));
    case ($urandom_range(3))
      0: return mmac_pkg::C_MAX - gap;
      1: return mmac_pkg::C_MIN + gap;
      2: return raw[C_W-1:0];
      default: return C_W'(signed'(raw[31:0]));
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] rand_spare_cmd();
    case ($urandom_range(2))
      0: return CMD_SPARE_5;
      1: return CMD_SPARE_6;
      default: return CMD_SPARE_7;
    endcase
  endfunction

  // Load every entry so that no compute or read meets an unwritten one
  task automatic test_fill_stores();
    for (int r = 0; r < N_MAX; r++) begin
      for (int c = 0; c < N_MAX; c++) begin
        send_item(mmac_pkg::CMD_WR_A, IDX_W'(r), IDX_W'(c), rand_ab_value());
        send_item(mmac_pkg::CMD_WR_B, IDX_W'(r), IDX_W'(c), rand_ab_value());
        send_item(mmac_pkg::CMD_WR_C, IDX_W'(r), IDX_W'(c), rand_c_value());
      end
    end
  endtask

  task automatic test_corners();
    // Clip high: most negative squared added to the top of C
    set_size(5'd1);
    send_item(mmac_pkg::CMD_WR_A, 4'd0, 4'd0, 48'hFFFF_FFFF_8000);
    send_item(mmac_pkg::CMD_WR_B, 4'd0, 4'd0, 48'h0000_0000_8000);
    send_item(mmac_pkg::CMD_WR_C, 4'd0, 4'd0, mmac_pkg::C_MAX);
    send_item(mmac_pkg::CMD_RD_C, 4'd0, 4'd0, '1);
    send_item(mmac_pkg::CMD_COMPUTE, 4'd0, 4'd0, '0);
    send_item(mmac_pkg::CMD_RD_C, 4'd0, 4'd0, '0);
    // Clip low: largest times most negative added to the bottom of C
    send_item(mmac_pkg::CMD_WR_A, 4'd0, 4'd0, 48'h0000_0000_7FFF);
    send_item(mmac_pkg::CMD_WR_C, 4'd0, 4'd0, mmac_pkg::C_MIN);
    send_item(mmac_pkg::CMD_COMPUTE, 4'd15, 4'd15, '1);
    send_item(mmac_pkg::CMD_RD_C, 4'd0, 4'd0, '0);
    // Far corner of the stores
    send_item(mmac_pkg::CMD_WR_C, 4'd15, 4'd15, -48'sd1);
    send_item(mmac_pkg::CMD_RD_C, 4'd15, 4'd15, '0);
    // Ignored commands with one or both index fields all ones
    send_item(CMD_SPARE_5, 4'd15, 4'd15, '1);
    send_item(CMD_SPARE_6, 4'd15, 4'd0, '1);
    send_item(CMD_SPARE_7, 4'd0, 4'd15, '0);
    // Size zero does no work but clears the clip flag
    set_size(5'd0);
    send_item(mmac_pkg::CMD_COMPUTE, 4'd0, 4'd0, '0);
    send_item(mmac_pkg::CMD_RD_C, 4'd0, 4'd0, '0);
    // Size beyond the store falls back to the full matrices
    set_size(5'd31);
    send_item(mmac_pkg::CMD_COMPUTE, 4'd0, 4'd0, '0);
    send_item(mmac_pkg::CMD_RD_C, 4'd15, 4'd15, '0);
    send_item(mmac_pkg::CMD_RD_C, 4'd7, 4'd9, '0);
  endtask

  // One phase of random items at a given size; computes land about n_compute times
  task automatic run_phase(input logic [SIZE_W-1:0] n, input int n_items,
                           input int n_compute, input int idle);
    int                   pick;
    logic [CMD_W-1:0]     cmd;
    logic signed [C_W-1:0] val;
    set_size(n);
    idle_pct = idle;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if ($urandom_range(n_items - 1) < n_compute) begin
        cmd = mmac_pkg::CMD_COMPUTE;
        val = C_W'({$urandom, $urandom});
      end else if (pick < 28) begin
        cmd = mmac_pkg::CMD_WR_A;
        val = rand_ab_value();
      end else if (pick < 44) begin
        cmd = mmac_pkg::CMD_WR_B;
        val = rand_ab_value();
      end else if (pick < 60) begin
        cmd = mmac_pkg::CMD_WR_C;
        val = rand_c_value();
      end else if (pick < 96) begin
        cmd = mmac_pkg::CMD_RD_C;
        val = C_W'({$urandom, $urandom});
      end else begin
        cmd = rand_spare_cmd();
        val = C_W'({$urandom, $urandom});
      end
      send_item(cmd, IDX_W'($urandom), IDX_W'($urandom), val);
    end
    idle_pct = 19;
  endtask

  task automatic test_random_sizes();
    run_phase(5'd1, 100, 10, 19);
    run_phase(5'd2, 100, 10, 19);
    run_phase(5'd3, 100, 10, 19);
    run_phase(5'd4, 100, 8, 19);
    run_phase(5'd5, 80, 6, 19);
    run_phase(5'd8, 60, 4, 19);
    run_phase(5'd0, 40, 5, 19);
    run_phase(5'd16, 30, 2, 19);
    run_phase(5'd31, 20, 1, 19);
    run_phase(SIZE_W'($urandom_range(6, 1)), 80, 8, 19);
  endtask

  // Back-to-back items with no idling at all
  task automatic test_streaming();
    run_phase(5'd3, 150, 10, 0);
  endtask

  // Compare each result with the oldest prediction
  always @(posedge clk) begin : check_result
    mmac_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result item with no prediction pending");
      end else begin
        want = pending_results.pop_front();
        if (out_value !== want.value)
          report_mismatch($sformatf("out_value %h, predicted %h", out_value, want.value));
        if (out_compute_done !== want.done)
          report_mismatch($sformatf("out_compute_done %b, predicted %b",
                                    out_compute_done, want.done));
        if (out_saturated !== want.sat)
          report_mismatch($sformatf("out_saturated %b, predicted %b",
                                    out_saturated, want.sat));
      end
    end
  end

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      a_mirror[i] = '0;
      b_mirror[i] = '0;
      c_mirror[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_stores();
    test_corners();
    test_random_sizes();
    test_streaming();

    // Drain and settle
    wait_quiet();
    repeat (16) @(posedge clk);
    if (pending_results.size() == 0 && error_count == 0) begin
      $display("matrix_multiply_accumulate verification clean");
    end else begin
      $display("matrix_multiply_accumulate verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mmac_pkg.sv
rtl/mmac_mac.sv
rtl/matrix_multiply_accumulate.sv
bench/testbench.sv
